[rtl/rhfp_pkg.sv]
// Package for the RFID hex frame parser: sizes, character codes, status codes
// and the parser state and result types. No dependencies.
package rhfp_pkg;

  localparam int unsigned DATA_BYTES   = 5;
  localparam int unsigned FRAME_DIGITS = 2 * (DATA_BYTES + 1);
  localparam int unsigned COUNT_LIMIT  = FRAME_DIGITS + 1;
  localparam int unsigned CODE_W       = 8 * DATA_BYTES;
  localparam int unsigned CNT_W        = $clog2(COUNT_LIMIT + 1);
  localparam int unsigned TAG_W        = 40;
  localparam int unsigned STATUS_W     = 3;
  localparam int unsigned OUT_W        = ((STATUS_W + TAG_W + 7) / 8) * 8;

  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_A   = 8'h41;
  localparam logic [7:0] CH_F   = 8'h46;

  localparam logic [STATUS_W-1:0] ST_VALID      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_START  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_CHECK  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG   = 3'd4;

  typedef struct packed {
    logic             in_frame;
    logic [CNT_W-1:0] digit_count;
    logic [3:0]       high_nibble;
    logic [7:0]       running_xor;
    logic [CODE_W-1:0] code_store;
    logic [7:0]       received_check;
  } rhfp_state_t;

  typedef struct packed {
    logic                valid;
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    tag_code;
  } rhfp_result_t;

endpackage

[rtl/rhfp_step.sv]
// Per-byte update of the frame parser: next state and the optional result.
// Depends on rhfp_pkg.
module rhfp_step (
  input  rhfp_pkg::rhfp_state_t  state_i,
  input  logic [7:0]             rx_byte_i,
  output rhfp_pkg::rhfp_state_t  state_o,
  output rhfp_pkg::rhfp_result_t result_o
);
  import rhfp_pkg::*;

  logic       is_digit;
  logic       is_upper;
  logic [3:0] nibble;
  logic [7:0] pair;

  always_comb begin
    is_digit = (rx_byte_i >= CH_0) && (rx_byte_i <= CH_9);
    is_upper = (rx_byte_i >= CH_A) && (rx_byte_i <= CH_F);
    if (is_digit) begin
      nibble = 4'(rx_byte_i - CH_0);
    end else begin
      nibble = 4'(rx_byte_i - CH_A + 8'd10);
    end
    pair = {state_i.high_nibble, nibble};
  end

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    if (!state_i.in_frame) begin
      if (rx_byte_i == CH_STX) begin
        state_o          = '0;
        state_o.in_frame = 1'b1;
      end else begin
        result_o.valid  = 1'b1;
        result_o.status = ST_BAD_START;
      end
    end else if ((rx_byte_i == CH_STX) || (rx_byte_i == CH_ETX)) begin
      state_o.in_frame = 1'b0;
      result_o.valid   = 1'b1;
      priority if (state_i.digit_count < CNT_W'(FRAME_DIGITS)) begin
        result_o.status = ST_INCOMPLETE;
      end else if (state_i.received_check != state_i.running_xor) begin
        result_o.status = ST_BAD_CHECK;
      end else if (state_i.digit_count == CNT_W'(FRAME_DIGITS)) begin
        result_o.status   = ST_VALID;
        result_o.tag_code = TAG_W'(state_i.code_store);
      end else begin
        result_o.status = ST_TOO_LONG;
      end
    end else if ((rx_byte_i != CH_LF) && (rx_byte_i != CH_CR) && (is_digit || is_upper)) begin
      if (state_i.digit_count < CNT_W'(FRAME_DIGITS)) begin
        if (!state_i.digit_count[0]) begin
          state_o.high_nibble = nibble;
        end else if ((state_i.digit_count >> 1) < CNT_W'(DATA_BYTES)) begin
          state_o.code_store  = CODE_W'({state_i.code_store, pair});
          state_o.running_xor = state_i.running_xor ^ pair;
        end else begin
          state_o.received_check = pair;
        end
      end
      if (state_i.digit_count < CNT_W'(COUNT_LIMIT)) begin
        state_o.digit_count = state_i.digit_count + CNT_W'(1);
      end
    end
  end

endmodule

[rtl/rfid_hex_frame_parser.sv]
// Top level of the RFID hex frame parser: input register, parser state and
// result register around rhfp_step. Depends on rhfp_pkg and rhfp_step.
//
//   Channel  Direction  Payload
//   s_axis   in         tdata[7:0] rx_byte
//   m_axis   out        tdata[2:0] status, tdata[42:3] tag_code
//
// Each byte is held in the input register and is then parsed into the
// result register, where its result, if any, can be taken; one byte per
// cycle while the result is not stalled.
// Reset closes any open frame and empties both registers.
// A stalled result holds the parse stage; the input register absorbs one more
// byte before s_axis_tready_o drops.
module rfid_hex_frame_parser (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [7:0]                s_axis_tdata_i,   // rx_byte
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [rhfp_pkg::OUT_W-1:0] m_axis_tdata_o   // status, tag_code
);
  import rhfp_pkg::*;

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  rhfp_state_t  state_q, state_d;
  rhfp_result_t step_res;
  logic         res_valid_q;
  logic [STATUS_W-1:0] res_status_q;
  logic [TAG_W-1:0]    res_tag_q;
  logic         fire;

  assign fire            = in_valid_q && (!res_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || fire;

  rhfp_step u_step (
    .state_i   (state_q),
    .rx_byte_i (in_byte_q),
    .state_o   (state_d),
    .result_o  (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (fire) begin
        state_q     <= state_d;
        res_valid_q <= step_res.valid;
      end else if (m_axis_tready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
    if (fire && step_res.valid) begin
      res_status_q <= step_res.status;
      res_tag_q    <= step_res.tag_code;
    end
  end

  assign m_axis_tvalid_o = res_valid_q;
  assign m_axis_tdata_o  = OUT_W'({res_tag_q, res_status_q});

endmodule

[rtl/rhfp_checker.sv]
// Port-level assertions for the RFID hex frame parser, bound to the top level.
// Depends on rhfp_pkg and rfid_hex_frame_parser.
module rhfp_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid_i,
  input logic                       s_axis_tready_o,
  input logic [7:0]                 s_axis_tdata_i,
  input logic                       m_axis_tvalid_o,
  input logic                       m_axis_tready_i,
  input logic [rhfp_pkg::OUT_W-1:0] m_axis_tdata_o
);
  import rhfp_pkg::*;

  logic unused_in;
  assign unused_in = s_axis_tvalid_i ^ (^s_axis_tdata_i);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("Result item dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("Stalled result item changed.");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[2:0] == ST_VALID) ||
      (m_axis_tdata_o[2:0] == ST_BAD_START) || (m_axis_tdata_o[2:0] == ST_INCOMPLETE) ||
      (m_axis_tdata_o[2:0] == ST_BAD_CHECK) || (m_axis_tdata_o[2:0] == ST_TOO_LONG))
    else $error("Status code out of range.");

  a_tag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[2:0] != ST_VALID) |-> (m_axis_tdata_o[42:3] == '0))
    else $error("Tag code not zero on a failed frame.");

  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("Input stalled without a stalled result.");

endmodule

bind rfid_hex_frame_parser rhfp_checker u_rhfp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
